// ===== rtl/rde_pkg.sv =====
// ============================================================================
// rde_pkg
// Shared types, codes and the control store of the radix digit emitter.
// ============================================================================
`default_nettype none

package rde_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 64;

   localparam logic [6:0] ASCII_ZERO         = 7'd48;
   localparam logic [6:0] ASCII_UPPER_OFFSET = 7'd55;
   localparam logic [6:0] ASCII_LOWER_OFFSET = 7'd55 + (7'd97 - 7'd65);

   localparam logic [1:0] FMT_DEC       = 2'd0;
   localparam logic [1:0] FMT_OCT       = 2'd1;
   localparam logic [1:0] FMT_HEX_LOWER = 2'd2;
   localparam logic [1:0] FMT_HEX_UPPER = 2'd3;

   typedef enum logic [2:0] {
      OP_LOAD,
      OP_SHIFT,
      OP_SKIP,
      OP_EMIT,
      OP_NOP
   } op_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_NO_REQ,
      COND_BIT_MORE,
      COND_LEAD_ZERO,
      COND_EMIT_AGAIN
   } cond_type;

   typedef logic [2:0] step_type;

   localparam step_type STEP_IDLE  = 3'd0;
   localparam step_type STEP_SHIFT = 3'd1;
   localparam step_type STEP_SKIP  = 3'd2;
   localparam step_type STEP_EMIT  = 3'd3;
   localparam step_type STEP_DONE  = 3'd4;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   typedef struct packed {
      logic bit_more;
      logic lead_zero;
      logic emit_again;
   } status_type;

   // Control store. A step jumps to its target when its condition holds,
   // and otherwise falls through to the next step.
   function automatic ctrl_word_type microcode(input step_type step);
      ctrl_word_type w;
      unique case (step)
         STEP_IDLE:  w = '{op: OP_LOAD,  cond: COND_NO_REQ,     target: STEP_IDLE};
         STEP_SHIFT: w = '{op: OP_SHIFT, cond: COND_BIT_MORE,   target: STEP_SHIFT};
         STEP_SKIP:  w = '{op: OP_SKIP,  cond: COND_LEAD_ZERO,  target: STEP_SKIP};
         STEP_EMIT:  w = '{op: OP_EMIT,  cond: COND_EMIT_AGAIN, target: STEP_EMIT};
         STEP_DONE:  w = '{op: OP_NOP,   cond: COND_ALWAYS,     target: STEP_IDLE};
         default:    w = '{op: OP_NOP,   cond: COND_ALWAYS,     target: STEP_IDLE};
      endcase
      return w;
   endfunction

   // Half of the radix: a digit at or above it carries out when doubled.
   function automatic logic [3:0] radix_half(input logic [1:0] fmt);
      logic [3:0] h;
      unique case (fmt)
         FMT_DEC:       h = 4'd5;
         FMT_OCT:       h = 4'd4;
         FMT_HEX_LOWER: h = 4'd8;
         FMT_HEX_UPPER: h = 4'd8;
         default:       h = 4'd8;
      endcase
      return h;
   endfunction

   function automatic logic [6:0] digit_to_char(input logic [3:0] d, input logic [1:0] fmt);
      logic [6:0] base;
      if (d > 4'd9) begin
         base = (fmt == FMT_HEX_LOWER) ? ASCII_LOWER_OFFSET : ASCII_UPPER_OFFSET;
      end else begin
         base = ASCII_ZERO;
      end
      return base + {3'b000, d};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/rde_sequencer.sv =====
// ============================================================================
// rde_sequencer
// Step counter, control store lookup and conditional jump logic.
// ============================================================================
`default_nettype none

module rde_sequencer (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire rde_pkg::status_type    status,
   output rde_pkg::ctrl_word_type      ctrl
);

   rde_pkg::step_type upc_ff;
   rde_pkg::step_type upc_in;
   logic              take_jump;

   always_comb begin
      ctrl = rde_pkg::microcode(upc_ff);
      unique case (ctrl.cond)
         rde_pkg::COND_ALWAYS:     take_jump = 1'b1;
         rde_pkg::COND_NO_REQ:     take_jump = !req_valid;
         rde_pkg::COND_BIT_MORE:   take_jump = status.bit_more;
         rde_pkg::COND_LEAD_ZERO:  take_jump = status.lead_zero;
         rde_pkg::COND_EMIT_AGAIN: take_jump = status.emit_again;
         default:                  take_jump = 1'b1;
      endcase
      upc_in = take_jump ? ctrl.target : upc_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= rde_pkg::STEP_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rde_datapath.sv =====
// ============================================================================
// rde_datapath
// Bit-serial radix converter, digit store and registered character output.
// ============================================================================
`default_nettype none

module rde_datapath #(
   parameter int VALUE_WIDTH = rde_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rde_pkg::ctrl_word_type ctrl,
   input  wire logic                   req_valid,
   input  wire logic [VALUE_WIDTH-1:0] req_value,
   input  wire logic [1:0]             req_format_code,
   input  wire logic                   rsp_ready,
   output logic                        rsp_valid,
   output logic [6:0]                  rsp_digit_char,
   output logic                        rsp_last_char,
   output rde_pkg::status_type         status
);

   // Octal needs the most digits of all formats.
   localparam int NUM_DIGITS = (VALUE_WIDTH + 2) / 3;
   localparam int IDX_W      = $clog2(NUM_DIGITS);
   localparam int CNT_W      = $clog2(VALUE_WIDTH);

   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [1:0]             fmt_ff, fmt_in;
   logic [3:0]             digit_ff [NUM_DIGITS];
   logic [3:0]             digit_in [NUM_DIGITS];
   logic [CNT_W-1:0]       bitcnt_ff, bitcnt_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [6:0]             rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   carry [NUM_DIGITS];
   logic                   carry_in [NUM_DIGITS];
   logic [3:0]             half;
   logic [4:0]             radix;
   logic [4:0]             doubled [NUM_DIGITS];
   logic [4:0]             reduced [NUM_DIGITS];
   logic [3:0]             cur_digit;
   logic                   out_free;
   logic                   emit_load;

   always_comb begin
      half      = rde_pkg::radix_half(fmt_ff);
      radix     = {half, 1'b0};
      cur_digit = digit_ff[idx_ff];
      out_free  = !rsp_valid_ff || rsp_ready;

      // Doubling each digit and adding the incoming bit carries out exactly
      // when the digit is at least half the radix, so all digits update at once.
      for (int i = 0; i < NUM_DIGITS; i++) begin
         carry[i] = digit_ff[i] >= half;
      end
      for (int i = 0; i < NUM_DIGITS; i++) begin
         carry_in[i] = (i == 0) ? value_ff[VALUE_WIDTH-1] : carry[(i == 0) ? 0 : i - 1];
         doubled[i]  = {digit_ff[i], carry_in[i]};
         reduced[i]  = doubled[i] - (carry[i] ? radix : 5'd0);
      end

      status.bit_more   = bitcnt_ff != '0;
      status.lead_zero  = (cur_digit == 4'd0) && (idx_ff != '0);
      status.emit_again = !out_free || (idx_ff != '0);

      emit_load = (ctrl.op == rde_pkg::OP_EMIT) && out_free;

      value_in  = value_ff;
      fmt_in    = fmt_ff;
      digit_in  = digit_ff;
      bitcnt_in = bitcnt_ff;
      idx_in    = idx_ff;

      unique case (ctrl.op)
         rde_pkg::OP_LOAD: begin
            if (req_valid) begin
               value_in  = req_value;
               fmt_in    = req_format_code;
               bitcnt_in = CNT_W'(VALUE_WIDTH - 1);
               idx_in    = IDX_W'(NUM_DIGITS - 1);
               for (int i = 0; i < NUM_DIGITS; i++) begin
                  digit_in[i] = 4'd0;
               end
            end
         end
         rde_pkg::OP_SHIFT: begin
            value_in  = {value_ff[VALUE_WIDTH-2:0], 1'b0};
            bitcnt_in = bitcnt_ff - 1'b1;
            for (int i = 0; i < NUM_DIGITS; i++) begin
               digit_in[i] = reduced[i][3:0];
            end
         end
         rde_pkg::OP_SKIP: begin
            if (status.lead_zero) begin
               idx_in = idx_ff - 1'b1;
            end
         end
         rde_pkg::OP_EMIT: begin
            if (emit_load && (idx_ff != '0)) begin
               idx_in = idx_ff - 1'b1;
            end
         end
         rde_pkg::OP_NOP: begin
         end
         default: begin
         end
      endcase

      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      if (emit_load) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = rde_pkg::digit_to_char(cur_digit, fmt_ff);
         rsp_last_in  = idx_ff == '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      fmt_ff      <= fmt_in;
      digit_ff    <= digit_in;
      bitcnt_ff   <= bitcnt_in;
      idx_ff      <= idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last_char  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/radix_digit_emitter.sv =====
// ============================================================================
// radix_digit_emitter
// Converts an unsigned value to ASCII digits in decimal, octal or hex,
// most significant digit first, without leading zeros.
// ============================================================================
//
//   channel  direction  ports                                   meaning
//   req      in         req_value, req_format_code              value to convert
//   rsp      out        rsp_digit_char, rsp_last_char           one character
//
// A transaction on req passes through the load, shift, skip, emit and done
// steps in that order: shift converts the value bit by bit, skip passes over
// leading zero digits to the first digit and emit sends the characters.
// Reset is synchronous and returns the step counter to its idle step. A
// stalled rsp holds the emit step; a new req is taken while the last
// character may still wait in the output register.
//
`default_nettype none

module radix_digit_emitter #(
   parameter int VALUE_WIDTH = rde_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [VALUE_WIDTH-1:0] req_value,
   input  wire logic [1:0]             req_format_code,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [6:0]                  rsp_digit_char,
   output logic                        rsp_last_char
);

   rde_pkg::ctrl_word_type ctrl;
   rde_pkg::status_type    status;

   rde_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .ctrl      (ctrl)
   );

   rde_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .req_valid       (req_valid),
      .req_value       (req_value),
      .req_format_code (req_format_code),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_digit_char  (rsp_digit_char),
      .rsp_last_char   (rsp_last_char),
      .status          (status)
   );

   assign req_ready = ctrl.op == rde_pkg::OP_LOAD;

   // An accepted transaction always starts the conversion loop.
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("sequencer stayed idle after accepting a request");

   // A character only appears from the emit step.
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(ctrl.op == rde_pkg::OP_EMIT))
      else $error("response raised outside the emit step");

   // Every emitted character lies in the ASCII range from '0' to 'f'.
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_digit_char >= 7'd48) && (rsp_digit_char <= 7'd102)))
      else $error("emitted character outside the digit range");

endmodule

`default_nettype wire

// ===== test/radix_digit_emitter_tb.sv =====
// ============================================================================
// radix_digit_emitter_tb
// Self-checking testbench for the radix digit emitter. Each accepted value
// is converted by a local predictor into its expected digit characters.
// Every character on the rsp channel is compared in order with them.
// Directed values cover zero, full scale, digit-count boundaries and both
// hex cases. Random traffic then runs under several idle and stall mixes.
// ============================================================================
`default_nettype none

module radix_digit_emitter_tb;

   localparam int WIDTH       = 64;
   localparam int DRAIN_WAIT  = 160;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      logic [6:0] digit;
      logic       last;
   } digit_entry_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [WIDTH-1:0] req_value;
   logic [1:0]       req_format_code;
   logic             rsp_valid;
   logic             rsp_ready;
   logic [6:0]       rsp_digit_char;
   logic             rsp_last_char;

   digit_entry_type expected_digits[$];
   int              send_idle_pct;
   int              ready_stall_pct;
   int              mismatch_count;
   int              failure_count;
   int              cycle_count;

   radix_digit_emitter #(
      .VALUE_WIDTH(WIDTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .req_format_code(req_format_code),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_char  (rsp_last_char)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Receiver back-pressure, redrawn every cycle.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = ($urandom_range(99) >= ready_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Appends the digits of one value, most significant first.
   function automatic void predict_digits(input logic [WIDTH-1:0] value,
                                          input logic [1:0] fmt);
      logic [WIDTH-1:0] rest;
      logic [4:0]       radix;
      logic [6:0]       alpha_base;
      logic [3:0]       digit;
      logic [6:0]       chars[$];
      digit_entry_type  entry;
      rest = value;
      case (fmt)
         rde_pkg::FMT_DEC: radix = 5'd10;
         rde_pkg::FMT_OCT: radix = 5'd8;
         default:          radix = 5'd16;
      endcase
      alpha_base = (fmt == rde_pkg::FMT_HEX_LOWER) ? rde_pkg::ASCII_LOWER_OFFSET
                                                   : rde_pkg::ASCII_UPPER_OFFSET;
      do begin
         digit = 4'(rest % radix);
         chars.push_front((digit > 4'd9) ? alpha_base + 7'(digit)
                                         : rde_pkg::ASCII_ZERO + 7'(digit));
         rest = rest / radix;
      end while (rest != '0);
      foreach (chars[i]) begin
         entry.digit = chars[i];
         entry.last  = (i == chars.size() - 1);
         expected_digits.push_back(entry);
      end
   endfunction

   task automatic send_value(input logic [WIDTH-1:0] value, input logic [1:0] fmt);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_value       = value;
      req_format_code = fmt;
      do @(posedge clock); while (!req_ready);
      predict_digits(value, fmt);
   endtask

   always @(posedge clock) begin
      digit_entry_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_digits.size() == 0) begin
            failure_count++;
            if (mismatch_count < MAX_REPORTS)
               $display("unexpected character: digit=%0d last=%0b",
                        rsp_digit_char, rsp_last_char);
            mismatch_count++;
         end else begin
            want = expected_digits.pop_front();
            if (rsp_digit_char !== want.digit || rsp_last_char !== want.last) begin
               failure_count++;
               if (mismatch_count < MAX_REPORTS)
                  $display("mismatch: expected digit=%0d last=%0b, got digit=%0d last=%0b",
                           want.digit, want.last, rsp_digit_char, rsp_last_char);
               mismatch_count++;
            end
         end
      end
   end

   // Zero and full scale in every format.
   task automatic test_extremes();
      for (int f = 0; f < 4; f++) begin
         send_value('0, 2'(f));
         send_value('1, 2'(f));
      end
   endtask

   // Largest single digit and smallest two-digit value, plus deep powers.
   task automatic test_digit_boundaries();
      send_value(64'd9, rde_pkg::FMT_DEC);
      send_value(64'd10, rde_pkg::FMT_DEC);
      send_value(64'd7, rde_pkg::FMT_OCT);
      send_value(64'd8, rde_pkg::FMT_OCT);
      send_value(64'd15, rde_pkg::FMT_HEX_LOWER);
      send_value(64'd16, rde_pkg::FMT_HEX_UPPER);
      send_value(64'd10000000000000000000, rde_pkg::FMT_DEC);
      send_value(64'h8000000000000000, rde_pkg::FMT_OCT);
      send_value(64'h8000000000000000, rde_pkg::FMT_DEC);
      send_value(64'd1, rde_pkg::FMT_OCT);
   endtask

   // Letters must follow the requested case.
   task automatic test_hex_case();
      send_value(64'hABCDEF0123456789, rde_pkg::FMT_HEX_LOWER);
      send_value(64'hABCDEF0123456789, rde_pkg::FMT_HEX_UPPER);
      send_value(64'hFEDCBA9876543210, rde_pkg::FMT_HEX_LOWER);
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct,
                                      input int stall_pct);
      logic [WIDTH-1:0] value;
      send_idle_pct   = idle_pct;
      ready_stall_pct = stall_pct;
      repeat (count) begin
         case ($urandom_range(9))
            0:       value = '0;
            1:       value = '1;
            default: value = {$urandom, $urandom} >> $urandom_range(WIDTH - 1);
         endcase
         send_value(value, 2'($urandom_range(3)));
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_value       = '0;
      req_format_code = rde_pkg::FMT_DEC;
      send_idle_pct   = 0;
      ready_stall_pct = 0;
      mismatch_count  = 0;
      failure_count   = 0;
      cycle_count     = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_extremes();
      test_digit_boundaries();
      test_hex_case();
      test_random_traffic(80, 0, 0);
      test_random_traffic(80, 73, 0);
      test_random_traffic(80, 0, 73);
      test_random_traffic(80, 9, 9);

      @(negedge clock);
      req_valid = 1'b0;
      while (expected_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (expected_digits.size() != 0) failure_count++;
      if (failure_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
